// ----- src/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared widths, constants and types of the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int BYTE_W  = 8;
   localparam int CODE_W  = 21;
   localparam int USED_W  = 3;
   localparam int COUNT_W = 3;
   localparam int RCV_W   = 2;

   localparam logic [CODE_W-1:0] REPLACEMENT_CODE = 21'h00FFFD;

   // what one byte produces: count results, all replacements but the last
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [CODE_W-1:0]  code;
      logic               is_rep;
      logic [USED_W-1:0]  used;
   } desc_type;

endpackage

// ----- src/utf8d_step.sv -----
// ----------------------------------------------------------------------------
// utf8d_step
// Sequence state and per-byte decode: works out the results one byte causes.
// ----------------------------------------------------------------------------
module utf8d_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [utf8d_pkg::BYTE_W-1:0]     in_byte,
   input  logic                             end_of_text,
   output utf8d_pkg::desc_type              desc
);

   logic [2:0]                          exp_ff, exp_in;
   logic [utf8d_pkg::RCV_W-1:0]         rcv_ff, rcv_in;
   logic [utf8d_pkg::CODE_W-1:0]        part_ff, part_in;

   logic [2:0]                          ones;
   logic                                is_cont;
   logic                                seq_open;
   logic [utf8d_pkg::CODE_W-1:0]        shifted;
   logic [2:0]                          rcv_next;
   logic [2:0]                          flush;
   logic [utf8d_pkg::BYTE_W-1:0]        lead_mask;
   logic                                good;
   logic [utf8d_pkg::CODE_W-1:0]        good_code;
   logic [utf8d_pkg::USED_W-1:0]        good_used;
   logic [utf8d_pkg::COUNT_W-1:0]       count;

   // leading ones of the byte, capped at five
   always_comb begin
      casez (in_byte)
         8'b0???????: ones = 3'd0;
         8'b10??????: ones = 3'd1;
         8'b110?????: ones = 3'd2;
         8'b1110????: ones = 3'd3;
         8'b11110???: ones = 3'd4;
         default:     ones = 3'd5;
      endcase
   end

   assign is_cont   = (in_byte[7:6] == 2'b10);
   assign seq_open  = (exp_ff != 3'd0);
   assign shifted   = {part_ff[utf8d_pkg::CODE_W-7:0], in_byte[5:0]};
   assign rcv_next  = {1'b0, rcv_ff} + 3'd1;
   assign flush     = seq_open ? {1'b0, rcv_ff} : 3'd0;
   assign lead_mask = 8'hFF >> (ones + 3'd1);

   always_comb begin
      exp_in    = exp_ff;
      rcv_in    = rcv_ff;
      part_in   = part_ff;
      count     = 3'd0;
      good      = 1'b0;
      good_code = '0;
      good_used = 3'd1;
      if (seq_open && is_cont) begin
         if (rcv_next >= exp_ff) begin
            count     = 3'd1;
            good      = 1'b1;
            good_code = shifted;
            good_used = exp_ff;
            exp_in    = 3'd0;
            rcv_in    = '0;
            part_in   = '0;
         end else begin
            rcv_in  = rcv_next[utf8d_pkg::RCV_W-1:0];
            part_in = shifted;
            if (end_of_text) begin
               count   = rcv_next;
               exp_in  = 3'd0;
               rcv_in  = '0;
               part_in = '0;
            end
         end
      end else begin
         // a broken sequence gives one replacement per byte taken so far
         exp_in  = 3'd0;
         rcv_in  = '0;
         part_in = '0;
         case (ones)
            3'd0: begin
               count     = flush + 3'd1;
               good      = 1'b1;
               good_code = {{(utf8d_pkg::CODE_W-utf8d_pkg::BYTE_W){1'b0}}, in_byte};
               good_used = 3'd1;
            end
            3'd2, 3'd3, 3'd4: begin
               if (end_of_text) begin
                  count = flush + 3'd1;
               end else begin
                  count   = flush;
                  exp_in  = ones;
                  rcv_in  = 2'd1;
                  part_in = {{(utf8d_pkg::CODE_W-utf8d_pkg::BYTE_W){1'b0}},
                             in_byte & lead_mask};
               end
            end
            default: begin
               count = flush + 3'd1;
            end
         endcase
      end
   end

   assign desc.count  = count;
   assign desc.code   = good ? good_code : utf8d_pkg::REPLACEMENT_CODE;
   assign desc.is_rep = ~good;
   assign desc.used   = good ? good_used : 3'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= 3'd0;
         rcv_ff  <= '0;
         part_ff <= '0;
      end else if (advance) begin
         exp_ff  <= exp_in;
         rcv_ff  <= rcv_in;
         part_ff <= part_in;
      end
   end

`ifndef SYNTHESIS
   a_closed_clean: assert property (@(posedge clock) disable iff (reset)
      (exp_ff == 3'd0) |-> (rcv_ff == '0 && part_ff == '0))
      else $error("closed sequence holds leftover state");

   a_open_sane: assert property (@(posedge clock) disable iff (reset)
      (exp_ff != 3'd0) |->
         ((exp_ff == 3'd2 || exp_ff == 3'd3 || exp_ff == 3'd4) &&
          rcv_ff != '0 && {1'b0, rcv_ff} < exp_ff))
      else $error("open sequence length or byte count out of range");
`endif

endmodule

// ----- src/utf8d_emit.sv -----
// ----------------------------------------------------------------------------
// utf8d_emit
// Result register: plays out the replacements and final result of one byte.
// ----------------------------------------------------------------------------
module utf8d_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  utf8d_pkg::desc_type   desc,
   output logic                  load_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // code_point[20:0], bytes_used[23:21]
   output logic                  rsp_tuser,   // is_replacement
   output logic                  rsp_tlast    // last_of_run
);

   logic                                busy_ff, busy_in;
   logic [utf8d_pkg::COUNT_W-1:0]       left_ff, left_in;
   logic [utf8d_pkg::CODE_W-1:0]        code_ff;
   logic                                rep_ff;
   logic [utf8d_pkg::USED_W-1:0]        used_ff;
   logic                                fire;
   logic                                final_one;

   assign fire       = busy_ff && rsp_tready;
   assign final_one  = (left_ff == 3'd1);
   assign load_ready = !busy_ff || (final_one && rsp_tready);

   always_comb begin
      busy_in = busy_ff;
      left_in = left_ff;
      if (load) begin
         busy_in = 1'b1;
         left_in = desc.count;
      end else if (fire) begin
         busy_in = !final_one;
         left_in = left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= desc.code;
         rep_ff  <= desc.is_rep;
         used_ff <= desc.used;
      end
   end

   // earlier results of a run are always replacements
   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = final_one;
   assign rsp_tdata  = final_one ? {used_ff, code_ff} : {3'd1, utf8d_pkg::REPLACEMENT_CODE};
   assign rsp_tuser  = final_one ? rep_ff : 1'b1;

`ifndef SYNTHESIS
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (left_ff != '0 && left_ff <= 3'd4))
      else $error("result count out of range");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rsp_tready && left_ff > 3'd1) |=> (busy_ff && left_ff == $past(left_ff) - 3'd1))
      else $error("run of results cut short");
`endif

endmodule

// ----- src/utf8_code_point_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_code_point_decoder
// Timing: a byte's handshake fills the input register, and its results are then
// offered from the result register once that register can load them.
// Throughput: one byte per cycle while the result register is free; a byte
// with n results holds that register until all n are taken, while the next
// byte with results waits in the input register (no-result bytes never wait).
// Reset: synchronous; clears the open sequence and both valid registers.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // in_byte[7:0]
   input  logic         req_tlast,    // end_of_text
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,    // code_point[20:0], bytes_used[23:21]
   output logic         rsp_tuser,    // is_replacement
   output logic         rsp_tlast     // last_of_run
);

   logic                             in_valid_ff, in_valid_in;
   logic [utf8d_pkg::BYTE_W-1:0]     in_byte_ff;
   logic                             in_eot_ff;
   logic                             advance;
   logic                             load;
   logic                             load_ready;
   logic                             take;
   utf8d_pkg::desc_type              desc;

   // a byte with no results only moves the sequence state
   assign advance    = in_valid_ff && ((desc.count == '0) || load_ready);
   assign load       = advance && (desc.count != '0);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_tdata;
         in_eot_ff  <= req_tlast;
      end
   end

   utf8d_step u_step (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_byte     (in_byte_ff),
      .end_of_text (in_eot_ff),
      .desc        (desc)
   );

   utf8d_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .desc       (desc),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
